/* src/line_raster_eight_zone_assert.svh */
// Assertion macros for the eight-zone line rasterizer.
// Sampled on clock, disabled while reset is high; define NO_ASSERTIONS to drop them.
`ifndef LINE_RASTER_EIGHT_ZONE_ASSERT_SVH
`define LINE_RASTER_EIGHT_ZONE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LRE_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("line raster assertion failed");
`define LRE_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("line raster assertion failed");
`else
`define LRE_ASSERT_IMP(label, ante, cons)
`define LRE_ASSERT_NXT(label, ante, cons)
`endif
`endif

/* src/lre_pkg.sv */
// Shared types and constants for the eight-zone line rasterizer.
// No dependencies.
package lre_pkg;

   localparam int COORD_BITS_DEF = 12;

   localparam logic CMD_START   = 1'b0;
   localparam logic CMD_ADVANCE = 1'b1;

   typedef enum logic [2:0] {
      ZONE_0 = 3'd0,
      ZONE_1 = 3'd1,
      ZONE_2 = 3'd2,
      ZONE_3 = 3'd3,
      ZONE_4 = 3'd4,
      ZONE_5 = 3'd5,
      ZONE_6 = 3'd6,
      ZONE_7 = 3'd7
   } zone_type;

   typedef struct packed {
      zone_type zone;
      logic     single;
   } setup_ctl_type;

endpackage

/* src/lre_if.sv */
// Valid/ready channel interfaces for the line rasterizer request and response.
// Depends on lre_pkg for the default coordinate width.
interface lre_req_if
   import lre_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic                         command;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;

   modport source (output valid, command, start_x, start_y, end_x, end_y, input ready);
   modport sink (input valid, command, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lre_rsp_if
   import lre_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] pixel_x;
   logic signed [COORD_BITS-1:0] pixel_y;
   logic                         valid_res;
   logic                         last;

   modport source (output valid, pixel_x, pixel_y, valid_res, last, input ready);
   modport sink (input valid, pixel_x, pixel_y, valid_res, last, output ready);
endinterface

/* src/lre_setup.sv */
// Line setup: zone classification, folding into zone 0 and decision terms.
// Depends on lre_pkg.
module lre_setup
   import lre_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic signed [COORD_BITS-1:0] start_x,
   input  logic signed [COORD_BITS-1:0] start_y,
   input  logic signed [COORD_BITS-1:0] end_x,
   input  logic signed [COORD_BITS-1:0] end_y,
   output setup_ctl_type                setup_ctl,
   output logic signed [COORD_BITS:0]   walk_x,
   output logic signed [COORD_BITS:0]   walk_y,
   output logic signed [COORD_BITS:0]   walk_limit,
   output logic signed [COORD_BITS+2:0] decision,
   output logic signed [COORD_BITS+2:0] step_straight,
   output logic signed [COORD_BITS+2:0] step_diagonal
);

   localparam int W = COORD_BITS + 1;

   logic signed [W-1:0] sx, sy, ex, ey;
   logic signed [W-1:0] dx, dy, abs_dx, abs_dy;
   logic signed [W-1:0] dxf, dyf, diff;
   zone_type            zone;

   function automatic logic signed [2*W-1:0] fold_pt(zone_type z, logic signed [W-1:0] x,
                                                    logic signed [W-1:0] y);
      logic signed [W-1:0] fx, fy;
      case (z)
         ZONE_0: begin fx = x;  fy = y;  end
         ZONE_1: begin fx = y;  fy = x;  end
         ZONE_2: begin fx = y;  fy = -x; end
         ZONE_3: begin fx = -x; fy = y;  end
         ZONE_4: begin fx = -x; fy = -y; end
         ZONE_5: begin fx = -y; fy = -x; end
         ZONE_6: begin fx = -y; fy = x;  end
         default: begin fx = x; fy = -y; end
      endcase
      return {fx, fy};
   endfunction

   assign sx = {start_x[COORD_BITS-1], start_x};
   assign sy = {start_y[COORD_BITS-1], start_y};
   assign ex = {end_x[COORD_BITS-1], end_x};
   assign ey = {end_y[COORD_BITS-1], end_y};

   assign dx     = ex - sx;
   assign dy     = ey - sy;
   assign abs_dx = dx[W-1] ? -dx : dx;
   assign abs_dy = dy[W-1] ? -dy : dy;

   always_comb begin
      case ({dx[W-1], dy[W-1]})
         2'b00:   zone = (abs_dx >= abs_dy) ? ZONE_0 : ZONE_1;
         2'b10:   zone = (abs_dx >= abs_dy) ? ZONE_3 : ZONE_2;
         2'b11:   zone = (abs_dx >= abs_dy) ? ZONE_4 : ZONE_5;
         default: zone = (abs_dx >= abs_dy) ? ZONE_7 : ZONE_6;
      endcase
   end

   assign {walk_x, walk_y} = fold_pt(zone, sx, sy);
   assign {dxf, dyf}       = fold_pt(zone, dx, dy);
   assign walk_limit       = walk_x + dxf;

   assign diff          = dyf - dxf;
   assign step_straight = {dyf[W-1], dyf, 1'b0};
   assign step_diagonal = {diff[W-1], diff, 1'b0};
   assign decision      = step_straight - {{2{dxf[W-1]}}, dxf};

   assign setup_ctl.zone   = zone;
   assign setup_ctl.single = (dxf == '0);

endmodule

/* src/lre_stepper.sv */
// Walk state and midpoint step, with mapping of each pixel back to its zone.
// Depends on lre_pkg; takes folded line terms from lre_setup.
module lre_stepper
   import lre_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         xfer,
   input  logic                         command,
   input  logic signed [COORD_BITS-1:0] start_x,
   input  logic signed [COORD_BITS-1:0] start_y,
   input  setup_ctl_type                setup_ctl,
   input  logic signed [COORD_BITS:0]   setup_walk_x,
   input  logic signed [COORD_BITS:0]   setup_walk_y,
   input  logic signed [COORD_BITS:0]   setup_walk_limit,
   input  logic signed [COORD_BITS+2:0] setup_decision,
   input  logic signed [COORD_BITS+2:0] setup_step_straight,
   input  logic signed [COORD_BITS+2:0] setup_step_diagonal,
   output logic signed [COORD_BITS-1:0] pixel_x,
   output logic signed [COORD_BITS-1:0] pixel_y,
   output logic                         valid_res,
   output logic                         last,
   output logic                         line_active
);

   localparam int W = COORD_BITS + 1;
   localparam int D = COORD_BITS + 3;

   logic                active_ff, active_in;
   zone_type            zone_ff, zone_in;
   logic signed [W-1:0] walk_x_ff, walk_x_in;
   logic signed [W-1:0] walk_y_ff, walk_y_in;
   logic signed [W-1:0] limit_ff, limit_in;
   logic signed [D-1:0] decision_ff, decision_in;
   logic signed [D-1:0] straight_ff, straight_in;
   logic signed [D-1:0] diagonal_ff, diagonal_in;

   logic signed [W-1:0] next_x, next_y, ox, oy;
   logic signed [D-1:0] next_dec;
   logic                go_diag, next_fin;

   assign go_diag  = !decision_ff[D-1];
   assign next_x   = walk_x_ff + W'(1);
   assign next_y   = go_diag ? walk_y_ff + W'(1) : walk_y_ff;
   assign next_dec = decision_ff + (go_diag ? diagonal_ff : straight_ff);
   assign next_fin = (next_x >= limit_ff);

   always_comb begin
      case (zone_ff)
         ZONE_0: begin ox = next_x;  oy = next_y;  end
         ZONE_1: begin ox = next_y;  oy = next_x;  end
         ZONE_2: begin ox = -next_y; oy = next_x;  end
         ZONE_3: begin ox = -next_x; oy = next_y;  end
         ZONE_4: begin ox = -next_x; oy = -next_y; end
         ZONE_5: begin ox = -next_y; oy = -next_x; end
         ZONE_6: begin ox = next_y;  oy = -next_x; end
         default: begin ox = next_x; oy = -next_y; end
      endcase
   end

   always_comb begin
      active_in   = active_ff;
      zone_in     = zone_ff;
      walk_x_in   = walk_x_ff;
      walk_y_in   = walk_y_ff;
      limit_in    = limit_ff;
      decision_in = decision_ff;
      straight_in = straight_ff;
      diagonal_in = diagonal_ff;
      pixel_x     = '0;
      pixel_y     = '0;
      valid_res   = 1'b0;
      last        = 1'b0;
      if (command == CMD_START) begin
         active_in   = !setup_ctl.single;
         zone_in     = setup_ctl.zone;
         walk_x_in   = setup_walk_x;
         walk_y_in   = setup_walk_y;
         limit_in    = setup_walk_limit;
         decision_in = setup_decision;
         straight_in = setup_step_straight;
         diagonal_in = setup_step_diagonal;
         pixel_x     = start_x;
         pixel_y     = start_y;
         valid_res   = 1'b1;
         last        = setup_ctl.single;
      end else if (active_ff) begin
         active_in   = !next_fin;
         walk_x_in   = next_x;
         walk_y_in   = next_y;
         decision_in = next_dec;
         pixel_x     = ox[COORD_BITS-1:0];
         pixel_y     = oy[COORD_BITS-1:0];
         valid_res   = 1'b1;
         last        = next_fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         zone_ff     <= ZONE_0;
         walk_x_ff   <= '0;
         walk_y_ff   <= '0;
         limit_ff    <= '0;
         decision_ff <= '0;
         straight_ff <= '0;
         diagonal_ff <= '0;
      end else if (xfer) begin
         active_ff   <= active_in;
         zone_ff     <= zone_in;
         walk_x_ff   <= walk_x_in;
         walk_y_ff   <= walk_y_in;
         limit_ff    <= limit_in;
         decision_ff <= decision_in;
         straight_ff <= straight_in;
         diagonal_ff <= diagonal_in;
      end
   end

   assign line_active = active_ff;

endmodule

/* src/line_raster_eight_zone.sv */
// Top level of the eight-zone midpoint line rasterizer: handshake and result register.
// Depends on lre_pkg, lre_if, lre_setup, lre_stepper and the assertion macro header.
//
// Send a start command with two endpoints to get the first pixel, then one advance
// command per further pixel; the pixel marked last ends the line, and an advance with
// no line active returns a result with valid_res low. One command is taken every clock
// cycle while the request side is not stalled, and its result appears in the result
// register in the cycle after the transfer. The request side stalls only while that
// register holds a result the sink has not taken, so throughput is one pixel per cycle
// while the sink takes results. A start while a line is active abandons the old line.
`include "line_raster_eight_zone_assert.svh"

module line_raster_eight_zone
   import lre_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   lre_req_if.sink  req_chan,
   lre_rsp_if.source rsp_chan
);

   setup_ctl_type                setup_ctl;
   logic signed [COORD_BITS:0]   su_walk_x, su_walk_y, su_limit;
   logic signed [COORD_BITS+2:0] su_decision, su_straight, su_diagonal;

   logic signed [COORD_BITS-1:0] emit_x, emit_y;
   logic                         emit_valid_res, emit_last, line_active;
   logic                         xfer;

   logic                         rsp_valid_ff;
   logic signed [COORD_BITS-1:0] pixel_x_ff, pixel_y_ff;
   logic                         valid_res_ff, last_ff;

   logic                         is_start, blank_px;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign xfer           = req_chan.valid && req_chan.ready;

   lre_setup #(
      .COORD_BITS(COORD_BITS)
   ) u_setup (
      .start_x      (req_chan.start_x),
      .start_y      (req_chan.start_y),
      .end_x        (req_chan.end_x),
      .end_y        (req_chan.end_y),
      .setup_ctl    (setup_ctl),
      .walk_x       (su_walk_x),
      .walk_y       (su_walk_y),
      .walk_limit   (su_limit),
      .decision     (su_decision),
      .step_straight(su_straight),
      .step_diagonal(su_diagonal)
   );

   lre_stepper #(
      .COORD_BITS(COORD_BITS)
   ) u_stepper (
      .clock              (clock),
      .reset              (reset),
      .xfer               (xfer),
      .command            (req_chan.command),
      .start_x            (req_chan.start_x),
      .start_y            (req_chan.start_y),
      .setup_ctl          (setup_ctl),
      .setup_walk_x       (su_walk_x),
      .setup_walk_y       (su_walk_y),
      .setup_walk_limit   (su_limit),
      .setup_decision     (su_decision),
      .setup_step_straight(su_straight),
      .setup_step_diagonal(su_diagonal),
      .pixel_x            (emit_x),
      .pixel_y            (emit_y),
      .valid_res          (emit_valid_res),
      .last               (emit_last),
      .line_active        (line_active)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (xfer) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (xfer) begin
         pixel_x_ff   <= emit_x;
         pixel_y_ff   <= emit_y;
         valid_res_ff <= emit_valid_res;
         last_ff      <= emit_last;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.pixel_x   = pixel_x_ff;
   assign rsp_chan.pixel_y   = pixel_y_ff;
   assign rsp_chan.valid_res = valid_res_ff;
   assign rsp_chan.last      = last_ff;

   assign is_start = (req_chan.command == CMD_START);
   assign blank_px = (pixel_x_ff == '0) && (pixel_y_ff == '0) && !last_ff;

   `LRE_ASSERT_NXT(a_xfer_gives_result, xfer, rsp_valid_ff)
   `LRE_ASSERT_NXT(a_start_sets_active, xfer && is_start, line_active == !last_ff)
   `LRE_ASSERT_IMP(a_idle_result_blank, rsp_valid_ff && !valid_res_ff, blank_px)
   `LRE_ASSERT_NXT(a_last_ends_line, xfer && emit_last, !line_active)

endmodule
